// ===== src/wsf_pkg.sv =====
package wsf_pkg;

	// queue and counter sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int COUNT_WIDTH = 16;

	// fixed field widths
	localparam int KIND_W   = 2;
	localparam int WEIGHT_W = 16;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;
	localparam int CAP_W    = 16;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int WCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W  = (COUNT_WIDTH > WEIGHT_W) ? COUNT_WIDTH : WEIGHT_W;
	localparam int ENTRY_W = ID_W + WEIGHT_W;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_ACQUIRE = 2'd0;
	localparam kind_t KIND_TRY     = 2'd1;
	localparam kind_t KIND_RELEASE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED        = 3'd0,
		ST_QUEUED         = 3'd1,
		ST_TRY_REFUSED    = 3'd2,
		ST_TOO_LARGE      = 3'd3,
		ST_QUEUE_FULL     = 3'd4,
		ST_RELEASED       = 3'd5,
		ST_UNDERFLOW      = 3'd6,
		ST_WAITER_GRANTED = 3'd7
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic latch_req;
		logic exec_single;
		logic rel_start;
		logic emit_pend;
		logic grant_head;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic no_result;
		logic rel_ok;
		logic head_fits;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/wsf_ifs.sv =====
interface wsf_req_if;
	import wsf_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0]   kind;
	logic [WEIGHT_W-1:0] weight;
	logic [ID_W-1:0]     requester_id;
	modport source (output valid, kind, weight, requester_id, input ready);
	modport sink (input valid, kind, weight, requester_id, output ready);
endinterface

interface wsf_rsp_if;
	import wsf_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     grant_id;
	logic [WEIGHT_W-1:0] grant_weight;
	logic                last;
	modport source (output valid, status, grant_id, grant_weight, last, input ready);
	modport sink (input valid, status, grant_id, grant_weight, last, output ready);
endinterface

interface wsf_cfg_if;
	import wsf_pkg::*;
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== src/wsf_ctrl.sv =====
module wsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  wsf_pkg::dp_stat_t stat,
	output wsf_pkg::dp_cmd_t  cmd
);
	import wsf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_CHECK,
		S_WAIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign req_ready = ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.latch_req = req_valid && ready_q;
			end
			S_EVAL: begin
				if (stat.no_result) begin
					cmd = '0;
				end else if (stat.rel_ok) begin
					cmd.rel_start = 1'b1;
				end else begin
					cmd.exec_single = stat.out_free;
				end
			end
			S_CHECK: begin
				cmd.emit_pend  = stat.out_free;
				cmd.grant_head = stat.out_free && stat.head_fits;
			end
			S_WAIT: begin
				cmd = '0;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid && ready_q) begin
						state_q <= S_EVAL;
						ready_q <= 1'b0;
					end
				end
				S_EVAL: begin
					if (stat.no_result) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end else if (stat.rel_ok) begin
						state_q <= S_CHECK;
					end else if (stat.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_CHECK: begin
					if (stat.out_free) begin
						if (stat.head_fits) begin
							state_q <= S_WAIT;
						end else begin
							state_q <= S_IDLE;
							ready_q <= 1'b1;
						end
					end
				end
				S_WAIT: begin
					state_q <= S_CHECK;
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== src/wsf_dp.sv =====
module wsf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsf_pkg::dp_cmd_t              cmd,
	output wsf_pkg::dp_stat_t             stat,
	input  logic [wsf_pkg::KIND_W-1:0]    req_kind,
	input  logic [wsf_pkg::WEIGHT_W-1:0]  req_weight,
	input  logic [wsf_pkg::ID_W-1:0]      req_id,
	input  logic                          cfg_we,
	input  logic [wsf_pkg::CAP_W-1:0]     cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wsf_pkg::STATUS_W-1:0]  out_status,
	output logic [wsf_pkg::ID_W-1:0]      out_id,
	output logic [wsf_pkg::WEIGHT_W-1:0]  out_weight,
	output logic                          out_last
);
	import wsf_pkg::*;

	localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'({COUNT_WIDTH{1'b1}});

	logic [CAP_W-1:0]       cap_q;
	logic [COUNT_WIDTH-1:0] in_use_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       tail_q;
	logic [WCNT_W-1:0]      count_q;

	kind_t                  kind_q;
	logic [WEIGHT_W-1:0]    w_q;
	logic [ID_W-1:0]        id_q;

	status_t                pend_status_q;
	logic [ID_W-1:0]        pend_id_q;
	logic [WEIGHT_W-1:0]    pend_w_q;

	logic [ENTRY_W-1:0]     mem [QUEUE_DEPTH];
	logic [ENTRY_W-1:0]     rd_q;

	logic                   out_valid_q;
	status_t                out_status_q;
	logic [ID_W-1:0]        out_id_q;
	logic [WEIGHT_W-1:0]    out_w_q;
	logic                   out_last_q;

	logic [CMP_W-1:0]       cap_clip;
	logic [CMP_W-1:0]       use_ext;
	logic [CMP_W-1:0]       w_ext;
	logic [CMP_W-1:0]       free_amt;
	logic [WEIGHT_W-1:0]    head_w;
	logic [ID_W-1:0]        head_id;
	logic                   queue_empty;
	logic                   queue_full;
	logic                   fits_now;
	logic                   head_fits;
	logic                   out_free;
	logic                   no_result;
	logic                   rel_ok;
	status_t                single_status;
	logic                   do_enq;
	logic                   out_load;
	logic [PTR_W-1:0]       head_next;
	logic [PTR_W-1:0]       tail_next;

	// free capacity, capacity clipped to the counter range
	assign cap_clip    = (CMP_W'(cap_q) > COUNT_MAX) ? COUNT_MAX : CMP_W'(cap_q);
	assign use_ext     = CMP_W'(in_use_q);
	assign w_ext       = CMP_W'(w_q);
	assign free_amt    = (use_ext >= cap_clip) ? '0 : cap_clip - use_ext;

	assign queue_empty = (count_q == '0);
	assign queue_full  = (count_q == WCNT_W'(QUEUE_DEPTH));
	assign fits_now    = (w_ext <= free_amt) && queue_empty;

	assign head_w      = rd_q[WEIGHT_W-1:0];
	assign head_id     = rd_q[WEIGHT_W +: ID_W];
	assign head_fits   = !queue_empty && (CMP_W'(head_w) <= free_amt);

	assign head_next   = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_next   = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		no_result     = 1'b0;
		rel_ok        = 1'b0;
		single_status = ST_UNDERFLOW;
		case (kind_q)
			KIND_ACQUIRE, KIND_TRY: begin
				if (fits_now) begin
					single_status = ST_GRANTED;
				end else if (kind_q == KIND_TRY) begin
					single_status = ST_TRY_REFUSED;
				end else if (w_q > cap_q) begin
					single_status = ST_TOO_LARGE;
				end else if (queue_full) begin
					single_status = ST_QUEUE_FULL;
				end else begin
					single_status = ST_QUEUED;
				end
			end
			KIND_RELEASE: begin
				rel_ok        = (w_ext <= use_ext);
				single_status = ST_UNDERFLOW;
			end
			default: begin
				no_result = 1'b1;
			end
		endcase
	end

	assign do_enq   = cmd.exec_single && (single_status == ST_QUEUED);
	assign out_load = cmd.exec_single || cmd.emit_pend;

	assign stat.no_result = no_result;
	assign stat.rel_ok    = rel_ok;
	assign stat.head_fits = head_fits;
	assign stat.out_free  = out_free;

	// request holding and pending result, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			kind_q <= req_kind;
			w_q    <= req_weight;
			id_q   <= req_id;
		end
		if (cmd.rel_start) begin
			pend_status_q <= ST_RELEASED;
			pend_id_q     <= id_q;
			pend_w_q      <= w_q;
		end else if (cmd.grant_head) begin
			pend_status_q <= ST_WAITER_GRANTED;
			pend_id_q     <= head_id;
			pend_w_q      <= head_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_W'(1);
			in_use_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.exec_single && (single_status == ST_GRANTED)) begin
				in_use_q <= COUNT_WIDTH'(use_ext + w_ext);
			end else if (cmd.rel_start) begin
				in_use_q <= COUNT_WIDTH'(use_ext - w_ext);
			end else if (cmd.grant_head) begin
				in_use_q <= COUNT_WIDTH'(use_ext + CMP_W'(head_w));
			end
			if (do_enq) begin
				tail_q  <= tail_next;
				count_q <= count_q + WCNT_W'(1);
			end else if (cmd.grant_head) begin
				head_q  <= head_next;
				count_q <= count_q - WCNT_W'(1);
			end
		end
	end

	// waiter store, registered read at the head
	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem[tail_q] <= {id_q, w_q};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_single) begin
			out_status_q <= single_status;
			out_id_q     <= id_q;
			out_w_q      <= w_q;
			out_last_q   <= 1'b1;
		end else if (cmd.emit_pend) begin
			out_status_q <= pend_status_q;
			out_id_q     <= pend_id_q;
			out_w_q      <= pend_w_q;
			out_last_q   <= !head_fits;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_id     = out_id_q;
	assign out_weight = out_w_q;
	assign out_last   = out_last_q;

endmodule

// ===== src/weighted_semaphore_fifo_top.sv =====
// a taken request is latched; a single-result request is decided in the evaluation state and
// its result registered once the result register is free; a release registers its released
// result and offers it from the check state; one request at a time, a release grants waiters
// head by head, one head read per grant; a result held by the receiver stalls the controller
// reset: arst_n clears the count in use, queue pointers and handshakes, capacity goes to 1;
// the waiter store is not cleared, only occupied entries are used
module weighted_semaphore_fifo_top (
	input  logic      clk,
	input  logic      arst_n,
	wsf_req_if.sink   req,
	wsf_rsp_if.source rsp,
	wsf_cfg_if.sink   cfg
);
	import wsf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// capacity writes always taken, unchecked; user writes only while the block is idle
	assign cfg.ready = 1'b1;

	// controller: one request at a time, walks release drains head by head
	wsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: count in use, capacity, waiter queue and the result register
	wsf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_kind   (req.kind),
		.req_weight (req.weight),
		.req_id     (req.requester_id),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_id     (rsp.grant_id),
		.out_weight (rsp.grant_weight),
		.out_last   (rsp.last)
	);

endmodule

// ===== tb/weighted_semaphore_fifo_top_tb.sv =====
`timescale 1ns / 100ps

module weighted_semaphore_fifo_top_tb;
	import wsf_pkg::*;

	// kind code the block ignores
	localparam kind_t KIND_UNUSED = 2'd3;

	localparam int HOLD_CYCLES   = 80;   // long receiver hold-off for back pressure
	localparam int SETTLE_CYCLES = 8;    // covers a request that gives no result
	localparam int STALL_LIMIT   = 2000; // cycles with no handshake at all
	localparam int PRINT_LIMIT   = 100;

	// one expected result of the semaphore
	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
	} sem_result_t;

	// one queued waiter
	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
	} waiter_t;

	// tracks capacity, weight in use and the waiter line, and predicts results
	class semaphore_ledger;
		logic [CAP_W-1:0]       capacity;
		logic [COUNT_WIDTH-1:0] in_use;
		waiter_t                waiters[$];
		sem_result_t            results[$];
		int                     errors;

		function new();
			capacity = CAP_W'(1);
			in_use   = '0;
			errors   = 0;
		endfunction

		function int pending();
			return results.size();
		endfunction

		// free weight is zero once capacity is no more than what is handed out
		function int unsigned free_weight();
			if (in_use >= capacity)
				return 0;
			return capacity - in_use;
		endfunction

		function void add_result(status_t status, logic [ID_W-1:0] id,
				logic [WEIGHT_W-1:0] weight);
			sem_result_t r;
			r.status = status;
			r.id     = id;
			r.weight = weight;
			r.last   = 1'b0;
			results.insert(results.size(), r);
		endfunction

		function void note_request(kind_t kind, logic [WEIGHT_W-1:0] weight,
				logic [ID_W-1:0] id);
			int          first;
			waiter_t     head;
			waiter_t     entry;
			sem_result_t tail;
			first = results.size();
			if (kind == KIND_ACQUIRE || kind == KIND_TRY) begin
				if (weight <= free_weight() && waiters.size() == 0) begin
					in_use = in_use + weight;
					add_result(ST_GRANTED, id, weight);
				end else if (kind == KIND_TRY) begin
					add_result(ST_TRY_REFUSED, id, weight);
				end else if (weight > capacity) begin
					add_result(ST_TOO_LARGE, id, weight);
				end else if (waiters.size() >= QUEUE_DEPTH) begin
					add_result(ST_QUEUE_FULL, id, weight);
				end else begin
					entry.id     = id;
					entry.weight = weight;
					waiters.insert(waiters.size(), entry);
					add_result(ST_QUEUED, id, weight);
				end
			end else if (kind == KIND_RELEASE) begin
				if (weight > in_use) begin
					add_result(ST_UNDERFLOW, id, weight);
				end else begin
					in_use = in_use - weight;
					add_result(ST_RELEASED, id, weight);
					// grant heads in order, stop at the first that does not fit
					while (waiters.size() > 0 && waiters[0].weight <= free_weight()) begin
						head = waiters[0];
						waiters.delete(0);
						in_use = in_use + head.weight;
						add_result(ST_WAITER_GRANTED, head.id, head.weight);
					end
				end
			end
			if (results.size() > first) begin
				tail = results[results.size() - 1];
				tail.last = 1'b1;
				results[results.size() - 1] = tail;
			end
		endfunction

		task report(string msg);
			if (errors < PRINT_LIMIT)
				$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id,
				logic [WEIGHT_W-1:0] weight, logic last);
			sem_result_t want;
			if (results.size() == 0) begin
				report($sformatf("unexpected result status %0d id %0d weight %0d last %0d",
					status, id, weight, last));
				return;
			end
			want = results[0];
			results.delete(0);
			if (status !== want.status)
				report($sformatf("status %0d, expected %0d", status, want.status));
			if (id !== want.id)
				report($sformatf("grant_id %0d, expected %0d", id, want.id));
			if (weight !== want.weight)
				report($sformatf("grant_weight %0d, expected %0d", weight, want.weight));
			if (last !== want.last)
				report($sformatf("last %0d, expected %0d", last, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wsf_req_if req_bus();
	wsf_rsp_if rsp_bus();
	wsf_cfg_if cfg_bus();

	weighted_semaphore_fifo_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	semaphore_ledger ledger;

	// idling knobs, percent of cycles
	int send_idle_pct;
	int recv_stall_pct;

	// set by the stimulus to start one long receiver hold-off
	logic hold_armed;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// everything is sampled at the rising edge; a result is checked before the
	// request of the same edge is noted, since results always trail their requests
	always @(posedge clk) begin
		if (rsp_bus.valid && rsp_bus.ready)
			ledger.check_result(rsp_bus.status, rsp_bus.grant_id, rsp_bus.grant_weight,
				rsp_bus.last);
		if (req_bus.valid && req_bus.ready)
			ledger.note_request(req_bus.kind, req_bus.weight, req_bus.requester_id);
		if (cfg_bus.valid && cfg_bus.ready)
			ledger.capacity = cfg_bus.data;
	end

	// result receiver: random stalls, plus a long hold-off counted here
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// ends the run when no channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("simulation failed");
		$finish;
	end

	// offer one request, with random idle cycles ahead of it; starts and ends at a falling
	// edge, so valid stays high from one request to the next unless idle cycles come between
	task automatic send_request(input kind_t kind, input logic [WEIGHT_W-1:0] weight,
			input logic [ID_W-1:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.kind         <= kind;
		req_bus.weight       <= weight;
		req_bus.requester_id <= id;
		do
			@(posedge clk);
		while (!req_bus.ready);
		@(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// sender goes quiet until every predicted result is back, then lets a
	// request with no result finish inside the block
	task automatic pause_until_drained();
		req_bus.valid <= 1'b0;
		do
			@(negedge clk);
		while (ledger.pending() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// random request shaped by the current capacity and weight in use, so that
	// waiters pile up and releases drain them
	task automatic pick_request(output kind_t kind, output logic [WEIGHT_W-1:0] weight,
			output logic [ID_W-1:0] id);
		int unsigned roll;
		int unsigned cap;
		int unsigned used;
		cap  = ledger.capacity;
		used = ledger.in_use;
		roll = $urandom_range(0, 99);
		id   = ID_W'($urandom);
		if (roll < 5) begin
			kind   = KIND_UNUSED;
			weight = WEIGHT_W'($urandom);
		end else if (roll < 62) begin
			kind = (roll < 50) ? KIND_ACQUIRE : KIND_TRY;
			roll = $urandom_range(0, 99);
			if (roll < 10)
				weight = '0;
			else if (roll < 20 && cap < 65535)
				weight = WEIGHT_W'($urandom_range(cap + 1, 65535));
			else if (roll < 30)
				weight = WEIGHT_W'($urandom);
			else
				weight = WEIGHT_W'($urandom_range(1, cap));
		end else begin
			kind = KIND_RELEASE;
			// mostly legal returns, the rest mostly underflow
			if ($urandom_range(0, 99) < 80)
				weight = WEIGHT_W'($urandom_range(0, used));
			else
				weight = WEIGHT_W'($urandom);
		end
	endtask

	// ignored requests do not count toward the total
	task automatic run_random(input int count);
		kind_t               kind;
		logic [WEIGHT_W-1:0] weight;
		logic [ID_W-1:0]     id;
		int                  done;
		done = 0;
		while (done < count) begin
			pick_request(kind, weight, id);
			send_request(kind, weight, id);
			if (kind != KIND_UNUSED)
				done++;
		end
	endtask

	// capacity only changes with nothing in flight
	task automatic start_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
			input int stall_pct);
		pause_until_drained();
		write_capacity(cap);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	// capacity 10: walks every status, fills the waiter line and drains it
	// with one release, which gives the longest result burst
	task automatic run_directed();
		send_request(KIND_ACQUIRE, 16'd0, 8'h00);   // zero weight, empty line
		send_request(KIND_ACQUIRE, 16'd10, 8'hFF);  // takes all capacity
		send_request(KIND_TRY, 16'd1, 8'h01);       // no room, refused
		send_request(KIND_ACQUIRE, 16'd11, 8'h02);  // can never fit
		send_request(KIND_ACQUIRE, 16'd3, 8'h03);   // first waiter
		send_request(KIND_ACQUIRE, 16'd0, 8'h04);   // zero weight behind a waiter
		send_request(KIND_TRY, 16'd0, 8'h05);       // refused, someone waits
		for (int i = 0; i < QUEUE_DEPTH - 2; i++)
			send_request(KIND_ACQUIRE, 16'd0, ID_W'(32 + i));
		send_request(KIND_ACQUIRE, 16'd1, 8'h06);   // waiter line full
		send_request(KIND_RELEASE, 16'd20, 8'h07);  // more than in use
		send_request(KIND_UNUSED, 16'hFFFF, 8'h08); // ignored
		send_request(KIND_RELEASE, 16'd10, 8'h09);  // grants every waiter
		send_request(KIND_RELEASE, 16'd3, 8'h0A);   // back to zero in use
	endtask

	initial begin
		ledger = new();
		hold_armed           = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		arst_n               = 1'b0;
		req_bus.valid        = 1'b0;
		req_bus.kind         = KIND_ACQUIRE;
		req_bus.weight       = '0;
		req_bus.requester_id = '0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.data         = '0;

		// single reset at the start
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, no idling
		write_capacity(16'd10);
		run_directed();

		// widest capacity, large weights reach the top bits
		start_phase(16'hFFFF, 0, 0);
		run_random(25);

		// capacity cut far below what is in use, so nothing is free
		start_phase(16'd40, 53, 0);
		run_random(25);

		// smallest capacity, receiver stalls
		start_phase(16'd1, 0, 53);
		run_random(25);

		// both sides idle a little; sender waits out all results midway
		start_phase(16'd300, 13, 13);
		run_random(15);
		pause_until_drained();
		run_random(15);

		// back pressure: receiver holds off while requests keep coming, so the
		// block fills and stops taking requests
		start_phase(16'd16, 0, 0);
		hold_armed = 1'b1;
		run_random(25);
		send_idle_pct  = 13;
		recv_stall_pct = 13;
		run_random(15);

		// widest capacity again frees any waiter stuck behind a small capacity
		start_phase(16'hFFFF, 0, 53);
		run_random(25);

		// wait for every result, then a short tail for anything stray
		pause_until_drained();

		if (ledger.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
